### design/dpdc_pkg.sv
// Package: item types and register indexes for the press duration classifier.
`default_nettype none

package dpdc_pkg;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam int LIMIT_BITS     = 4;
  localparam int THRESH_BITS    = 16;
  localparam int STAMP_BITS     = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_LIMIT   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_THRESHOLD   = 1'b1;

  localparam logic [LIMIT_BITS-1:0]  DEBOUNCE_LIMIT_RESET = 4'd3;
  localparam logic [THRESH_BITS-1:0] LONG_THRESHOLD_RESET = 16'd500;

  typedef struct packed {
    logic                  sample_pressed;
    logic [STAMP_BITS-1:0] now_ms;
    logic                  clear_detected;
  } poll_t;

  typedef struct packed {
    logic                  confirmed_pressed;
    logic                  release_now;
    logic                  detected;
    logic [STAMP_BITS-1:0] duration_ms;
    logic                  was_long;
    logic                  red_on;
    logic                  green_on;
  } result_t;

endpackage

`default_nettype wire

### design/dpdc_core.sv
// Core: debounce integrator, press timing and classification state.
`default_nettype none

module dpdc_core #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire dpdc_pkg::poll_t                   poll,
  input  wire logic [dpdc_pkg::LIMIT_BITS-1:0]   debounce_limit,
  input  wire logic [dpdc_pkg::THRESH_BITS-1:0]  long_press_threshold_ms,
  output dpdc_pkg::result_t                      result
);
  import dpdc_pkg::*;

  localparam int EXT_BITS = (TIME_BITS > STAMP_BITS) ? TIME_BITS : STAMP_BITS;

  logic [LIMIT_BITS-1:0]  integrator, integrator_next;
  logic                   confirmed, confirmed_next;
  logic [TIME_BITS-1:0]   press_start, press_start_next;
  logic [STAMP_BITS-1:0]  last_duration, last_duration_next;
  logic                   sticky_detected, sticky_detected_next;
  logic                   last_long, last_long_next;
  logic                   red_state, red_state_next;
  logic                   green_state, green_state_next;
  logic                   released;

  logic [EXT_BITS-1:0]    now_ext;
  logic [TIME_BITS-1:0]   now_tb;
  logic [TIME_BITS-1:0]   span;
  logic [EXT_BITS-1:0]    span_ext;
  logic                   span_long;

  assign now_ext   = EXT_BITS'(poll.now_ms);
  assign now_tb    = now_ext[TIME_BITS-1:0];
  assign span      = now_tb - press_start;
  assign span_ext  = EXT_BITS'(span);
  assign span_long = span >= TIME_BITS'(long_press_threshold_ms);

  always_comb begin
    integrator_next      = integrator;
    confirmed_next       = confirmed;
    press_start_next     = press_start;
    last_duration_next   = last_duration;
    last_long_next       = last_long;
    red_state_next       = red_state;
    green_state_next     = green_state;
    released             = 1'b0;

    if (poll.sample_pressed) begin
      if (integrator < debounce_limit) begin
        integrator_next = integrator + LIMIT_BITS'(1);
      end
    end else begin
      if (integrator != '0) begin
        integrator_next = integrator - LIMIT_BITS'(1);
      end
    end

    priority if (integrator_next >= debounce_limit && !confirmed) begin
      confirmed_next   = 1'b1;
      press_start_next = now_tb;
    end else if (integrator_next == '0 && confirmed) begin
      confirmed_next     = 1'b0;
      released           = 1'b1;
      last_duration_next = span_ext[STAMP_BITS-1:0];
      last_long_next     = span_long;
      red_state_next     = span_long;
      green_state_next   = !span_long;
    end

    sticky_detected_next = (sticky_detected && !poll.clear_detected) || released;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator      <= '0;
      confirmed       <= 1'b0;
      press_start     <= '0;
      last_duration   <= '0;
      sticky_detected <= 1'b0;
      last_long       <= 1'b0;
      red_state       <= 1'b0;
      green_state     <= 1'b0;
    end else if (advance) begin
      integrator      <= integrator_next;
      confirmed       <= confirmed_next;
      press_start     <= press_start_next;
      last_duration   <= last_duration_next;
      sticky_detected <= sticky_detected_next;
      last_long       <= last_long_next;
      red_state       <= red_state_next;
      green_state     <= green_state_next;
    end
  end

  always_comb begin
    result.confirmed_pressed = confirmed_next;
    result.release_now       = released;
    result.detected          = sticky_detected_next;
    result.duration_ms       = last_duration_next;
    result.was_long          = last_long_next;
    result.red_on            = red_state_next;
    result.green_on          = green_state_next;
  end

endmodule

`default_nettype wire

### design/debounced_press_duration_classifier.sv
// Top level: poll register, classifier core, result register and config registers.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------
//  poll     | in        | poll_valid / poll_stall   | dpdc_pkg::poll_t
//  result   | out       | result_valid / result_stall | dpdc_pkg::result_t
//  cfg      | in        | cfg_we                    | cfg_index, cfg_data
//
//  One item a cycle while the result is not stalled; an accepted poll item waits in the poll register first.
//  The poll register feeds the core, which updates its state as the item
//  moves into the result register.
//  Reset (synchronous, rst high) empties both registers and restores the
//  configuration to limit 3 and threshold 500 ms.
//  A stalled result holds; poll_stall rises only when both registers are full
//  and the result is stalled.
`default_nettype none

module debounced_press_duration_classifier #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  poll_valid,
  output logic                                       poll_stall,
  input  wire dpdc_pkg::poll_t                       poll,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output dpdc_pkg::result_t                          result,
  input  wire logic                                  cfg_we,
  input  wire logic [dpdc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [dpdc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import dpdc_pkg::*;

  logic [LIMIT_BITS-1:0]  debounce_limit;
  logic [THRESH_BITS-1:0] long_press_threshold_ms;

  poll_t   poll_q;
  logic    poll_q_valid;
  result_t step_result;
  logic    result_free;
  logic    advance;

  assign result_free = !result_valid || !result_stall;
  assign advance     = poll_q_valid && result_free;
  assign poll_stall  = poll_q_valid && !result_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit          <= DEBOUNCE_LIMIT_RESET;
      long_press_threshold_ms <= LONG_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_LIMIT: debounce_limit <= cfg_data[LIMIT_BITS-1:0];
        CFG_LONG_THRESHOLD: long_press_threshold_ms <= cfg_data[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid <= 1'b0;
    end else if (!poll_stall) begin
      poll_q_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!poll_stall && poll_valid) begin
      poll_q <= poll;
    end
  end

  dpdc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk                     (clk),
    .rst                     (rst),
    .advance                 (advance),
    .poll                    (poll_q),
    .debounce_limit          (debounce_limit),
    .long_press_threshold_ms (long_press_threshold_ms),
    .result                  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= poll_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

endmodule

`default_nettype wire

### design/dpdc_checker.sv
// Checker: port-level properties of the press duration classifier, bound to the top.
`default_nettype none

module dpdc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              poll_valid,
  input wire logic              poll_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire dpdc_pkg::result_t result
);
  import dpdc_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result item changed or dropped");

  a_release_state: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.release_now |-> !result.confirmed_pressed && result.detected)
    else $error("release item shows pressed state or no detected flag");

  a_release_lamps: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.release_now |->
      result.red_on == result.was_long && result.green_on == !result.was_long)
    else $error("indicators disagree with press class on release");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !poll_stall)
    else $error("pipeline not empty after reset");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(poll_valid && !poll_stall, 2))
    else $error("result item appeared with no poll item");

endmodule

bind debounced_press_duration_classifier dpdc_checker u_dpdc_checker (
  .clk          (clk),
  .rst          (rst),
  .poll_valid   (poll_valid),
  .poll_stall   (poll_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

### dv/debounced_press_duration_classifier_tb.sv
// Testbench for the debounced press duration classifier: random polls, scoreboard checking.
`timescale 1ns / 100ps

module debounced_press_duration_classifier_tb;
  import dpdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 117;
  localparam int DUR_BELOW      = 0;
  localparam int DUR_EXACT      = 1;
  localparam int DUR_ABOVE      = 2;
  localparam int DUR_ZERO       = 3;
  localparam int DUR_ANY        = 4;
  localparam int DUR_MAX        = 5;
  localparam int DUR_RANDOM     = -1;

  class press_checker;
    logic [LIMIT_BITS-1:0]  limit  = DEBOUNCE_LIMIT_RESET;
    logic [THRESH_BITS-1:0] thresh = LONG_THRESHOLD_RESET;
    logic [LIMIT_BITS-1:0]  integ     = '0;
    logic                   conf      = 1'b0;
    logic [STAMP_BITS-1:0]  press_t0  = '0;
    logic [STAMP_BITS-1:0]  last_dur  = '0;
    logic                   sticky    = 1'b0;
    logic                   last_long = 1'b0;
    logic                   red       = 1'b0;
    logic                   green     = 1'b0;
    result_t                pending_results[$];
    int                     errors;

    function void set_config(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == CFG_DEBOUNCE_LIMIT) begin
        limit = data[LIMIT_BITS-1:0];
      end else if (idx == CFG_LONG_THRESHOLD) begin
        thresh = data[THRESH_BITS-1:0];
      end
    endfunction

    function void note_poll(poll_t p);
      result_t r;
      logic    released;
      released = 1'b0;
      if (p.clear_detected) sticky = 1'b0;
      if (p.sample_pressed) begin
        if (integ < limit) integ = integ + 1'b1;
      end else if (integ != 0) begin
        integ = integ - 1'b1;
      end
      if (integ >= limit && !conf) begin
        conf     = 1'b1;
        press_t0 = p.now_ms;
      end else if (integ == 0 && conf) begin
        conf      = 1'b0;
        released  = 1'b1;
        last_dur  = p.now_ms - press_t0;
        last_long = (last_dur >= {16'd0, thresh});
        sticky    = 1'b1;
        red       = last_long;
        green     = !last_long;
      end
      r.confirmed_pressed = conf;
      r.release_now       = released;
      r.detected          = sticky;
      r.duration_ms       = last_dur;
      r.was_long          = last_long;
      r.red_on            = red;
      r.green_on          = green;
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", got.duration_ms, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.confirmed_pressed !== want.confirmed_pressed)
          report("confirmed_pressed", got.confirmed_pressed, want.confirmed_pressed);
        if (got.release_now !== want.release_now)
          report("release_now", got.release_now, want.release_now);
        if (got.detected !== want.detected)
          report("detected", got.detected, want.detected);
        if (got.duration_ms !== want.duration_ms)
          report("duration_ms", got.duration_ms, want.duration_ms);
        if (got.was_long !== want.was_long)
          report("was_long", got.was_long, want.was_long);
        if (got.red_on !== want.red_on)
          report("red_on", got.red_on, want.red_on);
        if (got.green_on !== want.green_on)
          report("green_on", got.green_on, want.green_on);
      end
    endtask
  endclass

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      poll_valid   = 1'b0;
  logic                      poll_stall;
  poll_t                     poll         = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  result_t                   result;
  logic                      cfg_we       = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  press_checker          sb = new;
  int                    n_sent;
  int                    cycle_no;
  int                    rx_until;
  int                    idle_cycles;
  bit                    no_idle;
  logic [STAMP_BITS-1:0] stamp;

  debounced_press_duration_classifier #(.TIME_BITS(32)) u_top (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll         (poll),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst && ((poll_valid && !poll_stall) || (result_valid && !result_stall))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(result);
      rx_until <= cycle_no + 1 + (no_idle ? 0 : $urandom_range(0, 18));
    end
  end

  always @(negedge clk) begin
    result_stall <= (cycle_no < rx_until);
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  task send_poll(poll_t p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      poll_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll_valid <= 1'b1;
    poll       <= p;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    sb.note_poll(p);
    n_sent++;
    @(negedge clk);
  endtask

  // stamp a releasing poll so that the press lasts the chosen duration
  task poll_once(bit pressed, bit clr, int dur_sel);
    poll_t                 p;
    logic [LIMIT_BITS-1:0] nxt;
    logic [STAMP_BITS-1:0] thr;
    logic [STAMP_BITS-1:0] dur;
    int                    sel;
    nxt = sb.integ;
    if (pressed) begin
      if (nxt < sb.limit) nxt = nxt + 1'b1;
    end else if (nxt != 0) begin
      nxt = nxt - 1'b1;
    end
    thr = {16'd0, sb.thresh};
    sel = (dur_sel < 0) ? $urandom_range(0, 7) : dur_sel;
    case (sel)
      DUR_BELOW: dur = thr - 1;
      DUR_EXACT: dur = thr;
      DUR_ABOVE: dur = thr + 1;
      DUR_ZERO:  dur = '0;
      DUR_ANY:   dur = $urandom;
      DUR_MAX:   dur = '1;
      default:   dur = $urandom_range(0, 2 * thr + 2);
    endcase
    p.sample_pressed = pressed;
    p.clear_detected = clr;
    p.now_ms         = (nxt == 0 && sb.conf) ? sb.press_t0 + dur : stamp;
    stamp = p.now_ms + (($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3));
    send_poll(p);
  endtask

  task drain_results();
    poll_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_config(idx, data);
    @(negedge clk);
  endtask

  task press_sequence();
    repeat ($urandom_range(0, 4))
      poll_once($urandom_range(0, 1), $urandom_range(0, 3) == 0, DUR_RANDOM);
    repeat (sb.limit + $urandom_range(0, 6))
      poll_once($urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0, DUR_RANDOM);
    repeat (sb.limit + $urandom_range(1, 4))
      poll_once($urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0, DUR_RANDOM);
  endtask

  initial begin
    int target;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // short press across the timestamp wrap
    stamp = 32'hFFFF_FFF0;
    repeat (3) poll_once(1'b1, 1'b0, DUR_RANDOM);
    poll_once(1'b0, 1'b0, DUR_RANDOM);
    poll_once(1'b0, 1'b0, DUR_RANDOM);
    poll_once(1'b0, 1'b0, DUR_BELOW);
    // long press, clear together with the release
    poll_once(1'b1, 1'b1, DUR_RANDOM);
    poll_once(1'b0, 1'b0, DUR_RANDOM);
    repeat (3) poll_once(1'b1, 1'b0, DUR_RANDOM);
    poll_once(1'b0, 1'b0, DUR_RANDOM);
    poll_once(1'b0, 1'b0, DUR_RANDOM);
    poll_once(1'b0, 1'b1, DUR_EXACT);
    // clear alone, timestamp extremes
    stamp = '0;
    poll_once(1'b0, 1'b1, DUR_RANDOM);
    stamp = '1;
    poll_once(1'b1, 1'b0, DUR_RANDOM);
    poll_once(1'b0, 1'b1, DUR_RANDOM);
    // zero limit: state toggles every poll
    drain_results();
    write_cfg(CFG_DEBOUNCE_LIMIT, 16'hFFF0);
    poll_once(1'b1, 1'b0, DUR_RANDOM);
    poll_once(1'b1, 1'b0, DUR_ABOVE);
    poll_once(1'b0, 1'b0, DUR_RANDOM);
    poll_once(1'b0, 1'b1, DUR_EXACT);
    poll_once(1'b1, 1'b0, DUR_RANDOM);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_cfg(CFG_DEBOUNCE_LIMIT, 16'h0001);
          write_cfg(CFG_LONG_THRESHOLD, 16'h0000);
        end
        1: begin
          write_cfg(CFG_DEBOUNCE_LIMIT, 16'hFFFF);
          write_cfg(CFG_LONG_THRESHOLD, 16'hFFFF);
        end
        2: begin
          write_cfg(CFG_DEBOUNCE_LIMIT, 16'hFFF0);
          write_cfg(CFG_LONG_THRESHOLD, 16'($urandom_range(0, 60)));
        end
        3: begin
          write_cfg(CFG_DEBOUNCE_LIMIT, {12'($urandom), 4'($urandom_range(1, 15))});
          write_cfg(CFG_LONG_THRESHOLD, 16'($urandom_range(0, 40)));
        end
        4: begin
          write_cfg(CFG_DEBOUNCE_LIMIT, 16'(DEBOUNCE_LIMIT_RESET));
          write_cfg(CFG_LONG_THRESHOLD, LONG_THRESHOLD_RESET);
        end
        default: begin
          write_cfg(CFG_DEBOUNCE_LIMIT, 16'($urandom));
          write_cfg(CFG_LONG_THRESHOLD, 16'($urandom));
        end
      endcase
      target = n_sent + PHASE_ITEMS;
      while (n_sent < target) begin
        if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8))
            poll_once($urandom_range(0, 1), $urandom_range(0, 3) == 0, DUR_RANDOM);
        end else begin
          press_sequence();
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
